@@ hw/rtl/qrs_pkg.sv @@
`timescale 1ns / 1ps
package qrs_pkg;

  typedef logic [2:0] kind_t;

  localparam kind_t KIND_ZERO    = 3'd0;
  localparam kind_t KIND_NONE    = 3'd1;
  localparam kind_t KIND_TWO     = 3'd2;
  localparam kind_t KIND_DOUBLE  = 3'd3;
  localparam kind_t KIND_COMPLEX = 3'd4;
  localparam kind_t KIND_LINEAR  = 3'd5;

  // stage handshake shared by the pipelined units
  typedef struct packed {
    logic en;
    logic valid;
  } stage_ctl_t;

endpackage

@@ hw/rtl/quadratic_root_solver.sv @@
`timescale 1ns / 1ps
// channel  direction  tdata (low bit up)                      tuser
// in_      slave      coef_a, coef_b, coef_c                  -
// out_     master     first_value, second_value               root_kind, saturated
//
// one coefficient set per cycle while the output register is empty or taken; the
// pipeline depth is set by the one-bit-per-stage square root and the
// one-bit-per-stage dividers
// rst_n clears the valid bits of every stage; data registers are not reset
// the whole pipeline advances while the output register is empty or taken,
// so a stall holds every transaction in place
module quadratic_root_solver
  import qrs_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // coef_a, coef_b, coef_c
  input  logic [((3*DATA_WIDTH+7)/8)*8-1:0]   in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // first_value, second_value
  output logic [((2*DATA_WIDTH+7)/8)*8-1:0]   out_tdata,
  // root_kind, saturated
  output logic [3:0]                          out_tuser
);

  localparam int W    = DATA_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int DW   = 2 * W + 1;
  localparam int SW   = W + 1;
  localparam int XW   = W + 2;
  localparam int DNW  = W + 1;
  localparam int NW   = XW + F;
  localparam int ODW  = ((2 * W + 7) / 8) * 8;

  typedef struct packed {
    logic         az;
    logic         bz;
    logic         cz;
    logic         an;
    logic         bn;
    logic         cn;
    logic         dneg;
    logic         dzero;
    logic [W-1:0] ma;
    logic [W-1:0] mb;
    logic [W-1:0] mc;
  } sq_sb_t;

  typedef struct packed {
    kind_t kind;
    logic  neg1;
    logic  an;
  } dv_sb_t;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // stage 1: magnitudes and signs
  logic [W-1:0] a_in, b_in, c_in;
  assign a_in = in_tdata[W-1:0];
  assign b_in = in_tdata[2*W-1:W];
  assign c_in = in_tdata[3*W-1:2*W];

  logic         s1_v_r;
  logic         s1_an_r, s1_bn_r, s1_cn_r;
  logic [W-1:0] s1_ma_r, s1_mb_r, s1_mc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_an_r <= a_in[W-1];
      s1_bn_r <= b_in[W-1];
      s1_cn_r <= c_in[W-1];
      s1_ma_r <= a_in[W-1] ? -a_in : a_in;
      s1_mb_r <= b_in[W-1] ? -b_in : b_in;
      s1_mc_r <= c_in[W-1] ? -c_in : c_in;
    end
  end

  // stage 2: b*b and a*c
  logic           s2_v_r;
  logic           s2_an_r, s2_bn_r, s2_cn_r;
  logic [W-1:0]   s2_ma_r, s2_mb_r, s2_mc_r;
  logic [2*W-1:0] s2_b2_r, s2_ac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_an_r <= s1_an_r;
      s2_bn_r <= s1_bn_r;
      s2_cn_r <= s1_cn_r;
      s2_ma_r <= s1_ma_r;
      s2_mb_r <= s1_mb_r;
      s2_mc_r <= s1_mc_r;
      s2_b2_r <= s1_mb_r * s1_mb_r;
      s2_ac_r <= s1_ma_r * s1_mc_r;
    end
  end

  // stage 3: exact discriminant magnitude and its sign
  logic [DW-1:0] b2_x, fac_x, d_nxt;
  logic          dneg_nxt;
  logic          cz2;

  assign b2_x  = {1'b0, s2_b2_r};
  assign fac_x = {s2_ac_r[2*W-2:0], 2'b00};
  assign cz2   = s2_mc_r == '0;

  always_comb begin
    dneg_nxt = 1'b0;
    if (!cz2 && (s2_an_r != s2_cn_r)) begin
      d_nxt = b2_x + fac_x;
    end else if (b2_x >= fac_x) begin
      d_nxt = b2_x - fac_x;
    end else begin
      d_nxt    = fac_x - b2_x;
      dneg_nxt = 1'b1;
    end
  end

  logic          s3_v_r;
  logic [DW-1:0] s3_d_r;
  sq_sb_t        s3_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_d_r        <= d_nxt;
      s3_sb_r.az    <= s2_ma_r == '0;
      s3_sb_r.bz    <= s2_mb_r == '0;
      s3_sb_r.cz    <= cz2;
      s3_sb_r.an    <= s2_an_r;
      s3_sb_r.bn    <= s2_bn_r;
      s3_sb_r.cn    <= s2_cn_r;
      s3_sb_r.dneg  <= dneg_nxt;
      s3_sb_r.dzero <= d_nxt == '0;
      s3_sb_r.ma    <= s2_ma_r;
      s3_sb_r.mb    <= s2_mb_r;
      s3_sb_r.mc    <= s2_mc_r;
    end
  end

  // square root
  stage_ctl_t        sq_ctl;
  logic              sq_v;
  logic [SW-1:0]     sq_root;
  logic [$bits(sq_sb_t)-1:0] sq_sb_raw;
  sq_sb_t            sq_sb;

  assign sq_ctl.en    = en;
  assign sq_ctl.valid = s3_v_r;
  assign sq_sb        = sq_sb_t'(sq_sb_raw);

  qrs_sqrt #(
    .IW  (2 * SW),
    .SBW ($bits(sq_sb_t))
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ctl    (sq_ctl),
    .in_rad    ({1'b0, s3_d_r}),
    .in_sb     (s3_sb_r),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_sb    (sq_sb_raw)
  );

  // stage 4: classify and pick the division operands
  logic signed [W+2:0] bs, sx, np, nm;
  logic [XW-1:0]       np_m, nm_m;
  kind_t               kind_nxt;
  logic [XW-1:0]       n1_nxt, n2_nxt;
  logic [DNW-1:0]      den_nxt;
  logic                neg1_nxt, neg2_nxt;
  logic                bneg_ab;

  assign bs   = sq_sb.bn ? -$signed({3'b000, sq_sb.mb}) : $signed({3'b000, sq_sb.mb});
  assign sx   = $signed({2'b00, sq_root});
  assign np   = sx - bs;
  assign nm   = -sx - bs;
  assign np_m = np[W+2] ? XW'(-np) : XW'(np);
  assign nm_m = nm[W+2] ? XW'(-nm) : XW'(nm);
  assign bneg_ab = !sq_sb.bz && (sq_sb.bn == sq_sb.an);

  always_comb begin
    n1_nxt   = XW'(sq_sb.mb);
    n2_nxt   = XW'(sq_root);
    den_nxt  = {sq_sb.ma, 1'b0};
    neg1_nxt = bneg_ab;
    neg2_nxt = 1'b0;
    if (sq_sb.az) begin
      n1_nxt   = XW'(sq_sb.mc);
      den_nxt  = DNW'(sq_sb.mb);
      neg1_nxt = !sq_sb.cz && (sq_sb.cn == sq_sb.bn);
      if (!sq_sb.bz) begin
        kind_nxt = KIND_LINEAR;
      end else if (sq_sb.cz) begin
        kind_nxt = KIND_ZERO;
      end else begin
        kind_nxt = KIND_NONE;
      end
    end else if (sq_sb.dneg) begin
      kind_nxt = KIND_COMPLEX;
    end else if (sq_sb.dzero) begin
      kind_nxt = KIND_DOUBLE;
    end else begin
      kind_nxt = KIND_TWO;
      n1_nxt   = np_m;
      n2_nxt   = nm_m;
      neg1_nxt = (np != '0) && (np[W+2] != sq_sb.an);
      neg2_nxt = (nm != '0) && (nm[W+2] != sq_sb.an);
    end
  end

  logic           s4_v_r;
  logic [XW-1:0]  s4_n1_r, s4_n2_r;
  logic [DNW-1:0] s4_den_r;
  dv_sb_t         s4_sb_r;
  logic           s4_neg2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_n1_r      <= n1_nxt;
      s4_n2_r      <= n2_nxt;
      s4_den_r     <= den_nxt;
      s4_sb_r.kind <= kind_nxt;
      s4_sb_r.neg1 <= neg1_nxt;
      s4_sb_r.an   <= sq_sb.an;
      s4_neg2_r    <= neg2_nxt;
    end
  end

  // two dividers side by side
  stage_ctl_t dv_ctl;
  logic       dv_v;
  logic [NW-1:0] q1, q2;
  logic [$bits(dv_sb_t)-1:0] dv_sb_raw;
  dv_sb_t     dv_sb;
  logic       neg2_q;

  assign dv_ctl.en    = en;
  assign dv_ctl.valid = s4_v_r;
  assign dv_sb        = dv_sb_t'(dv_sb_raw);

  qrs_div #(
    .NW  (NW),
    .DW  (DNW),
    .SBW ($bits(dv_sb_t))
  ) u_div1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ctl    (dv_ctl),
    .in_num    ({s4_n1_r, {F{1'b0}}}),
    .in_den    (s4_den_r),
    .in_sb     (s4_sb_r),
    .out_valid (dv_v),
    .out_quo   (q1),
    .out_sb    (dv_sb_raw)
  );

  qrs_div #(
    .NW  (NW),
    .DW  (DNW),
    .SBW (1)
  ) u_div2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ctl    (dv_ctl),
    .in_num    ({s4_n2_r, {F{1'b0}}}),
    .in_den    (s4_den_r),
    .in_sb     (s4_neg2_r),
    .out_valid (),
    .out_quo   (q2),
    .out_sb    (neg2_q)
  );

  // output stage: clamp, sign and order
  localparam logic [NW-1:0] LIM_POS = {{(NW-W){1'b0}}, 1'b0, {(W-1){1'b1}}};
  localparam logic [NW-1:0] LIM_NEG = {{(NW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};

  logic [NW-1:0] lim1, lim2;
  logic          sat1, sat2;
  logic [W-1:0]  m1, m2, r1, r2;
  logic [W-1:0]  v1_nxt, v2_nxt;
  logic          sat_nxt;

  assign lim1 = dv_sb.neg1 ? LIM_NEG : LIM_POS;
  assign lim2 = neg2_q ? LIM_NEG : LIM_POS;
  assign sat1 = q1 > lim1;
  assign sat2 = q2 > lim2;
  assign m1   = sat1 ? lim1[W-1:0] : q1[W-1:0];
  assign m2   = sat2 ? lim2[W-1:0] : q2[W-1:0];
  assign r1   = dv_sb.neg1 ? -m1 : m1;
  assign r2   = neg2_q ? -m2 : m2;

  always_comb begin
    case (dv_sb.kind)
      KIND_LINEAR, KIND_DOUBLE: begin
        v1_nxt  = r1;
        v2_nxt  = r1;
        sat_nxt = sat1;
      end
      KIND_COMPLEX: begin
        v1_nxt  = r1;
        v2_nxt  = r2;
        sat_nxt = sat1 | sat2;
      end
      KIND_TWO: begin
        v1_nxt  = dv_sb.an ? r2 : r1;
        v2_nxt  = dv_sb.an ? r1 : r2;
        sat_nxt = sat1 | sat2;
      end
      default: begin
        v1_nxt  = '0;
        v2_nxt  = '0;
        sat_nxt = 1'b0;
      end
    endcase
  end

  logic           out_v_r;
  logic [ODW-1:0] out_data_r;
  logic [3:0]     out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= ODW'({v2_nxt, v1_nxt});
      out_user_r <= {sat_nxt, dv_sb.kind};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

@@ hw/rtl/qrs_sqrt.sv @@
`timescale 1ns / 1ps
module qrs_sqrt
  import qrs_pkg::*;
#(
  parameter int IW  = 66,
  parameter int SBW = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  stage_ctl_t         in_ctl,
  input  logic [IW-1:0]      in_rad,
  input  logic [SBW-1:0]     in_sb,
  output logic               out_valid,
  output logic [IW/2-1:0]    out_root,
  output logic [SBW-1:0]     out_sb
);

  localparam int ST = IW / 2;
  localparam int RW = ST + 3;

  logic [IW-1:0]  rad_r  [ST];
  logic [RW-1:0]  rem_r  [ST];
  logic [ST-1:0]  root_r [ST];
  logic [SBW-1:0] sb_r   [ST];
  logic           v_r    [ST];

  // one root bit per stage, restoring digit recurrence
  for (genvar i = 0; i < ST; i++) begin : g_st
    logic [IW-1:0]  rad_in;
    logic [RW-1:0]  rem_in;
    logic [ST-1:0]  root_in;
    logic [SBW-1:0] sb_in;
    logic           v_in;
    logic [RW-1:0]  rem_sh;
    logic [RW-1:0]  trial;
    logic           ge;
    logic [RW-1:0]  rem_nxt;
    logic [ST-1:0]  root_nxt;

    if (i == 0) begin : g_first
      assign rad_in  = in_rad;
      assign rem_in  = '0;
      assign root_in = '0;
      assign sb_in   = in_sb;
      assign v_in    = in_ctl.valid;
    end else begin : g_next
      assign rad_in  = rad_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign sb_in   = sb_r[i-1];
      assign v_in    = v_r[i-1];
    end

    assign rem_sh   = {rem_in[RW-3:0], rad_in[IW-1 -: 2]};
    assign trial    = {1'b0, root_in, 2'b01};
    assign ge       = rem_sh >= trial;
    assign rem_nxt  = ge ? rem_sh - trial : rem_sh;
    assign root_nxt = {root_in[ST-2:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (in_ctl.en) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (in_ctl.en) begin
        rad_r[i]  <= {rad_in[IW-3:0], 2'b00};
        rem_r[i]  <= rem_nxt;
        root_r[i] <= root_nxt;
        sb_r[i]   <= sb_in;
      end
    end
  end

  assign out_valid = v_r[ST-1];
  assign out_root  = root_r[ST-1];
  assign out_sb    = sb_r[ST-1];

endmodule

@@ hw/rtl/qrs_div.sv @@
`timescale 1ns / 1ps
module qrs_div
  import qrs_pkg::*;
#(
  parameter int NW  = 50,
  parameter int DW  = 33,
  parameter int SBW = 5
) (
  input  logic           clk,
  input  logic           rst_n,
  input  stage_ctl_t     in_ctl,
  input  logic [NW-1:0]  in_num,
  input  logic [DW-1:0]  in_den,
  input  logic [SBW-1:0] in_sb,
  output logic           out_valid,
  output logic [NW-1:0]  out_quo,
  output logic [SBW-1:0] out_sb
);

  localparam int RW = DW + 1;

  // the numerator shifts out at the top while quotient bits shift in below
  logic [NW-1:0]  nq_r  [NW];
  logic [RW-1:0]  rem_r [NW];
  logic [DW-1:0]  den_r [NW];
  logic [SBW-1:0] sb_r  [NW];
  logic           v_r   [NW];

  for (genvar i = 0; i < NW; i++) begin : g_st
    logic [NW-1:0]  nq_in;
    logic [RW-1:0]  rem_in;
    logic [DW-1:0]  den_in;
    logic [SBW-1:0] sb_in;
    logic           v_in;
    logic [RW-1:0]  rem_sh;
    logic           ge;

    if (i == 0) begin : g_first
      assign nq_in  = in_num;
      assign rem_in = '0;
      assign den_in = in_den;
      assign sb_in  = in_sb;
      assign v_in   = in_ctl.valid;
    end else begin : g_next
      assign nq_in  = nq_r[i-1];
      assign rem_in = rem_r[i-1];
      assign den_in = den_r[i-1];
      assign sb_in  = sb_r[i-1];
      assign v_in   = v_r[i-1];
    end

    assign rem_sh = {rem_in[DW-1:0], nq_in[NW-1]};
    assign ge     = rem_sh >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (in_ctl.en) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (in_ctl.en) begin
        nq_r[i]  <= {nq_in[NW-2:0], ge};
        rem_r[i] <= ge ? rem_sh - {1'b0, den_in} : rem_sh;
        den_r[i] <= den_in;
        sb_r[i]  <= sb_in;
      end
    end
  end

  assign out_valid = v_r[NW-1];
  assign out_quo   = nq_r[NW-1];
  assign out_sb    = sb_r[NW-1];

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import qrs_pkg::*;

  localparam int FB = 16;
  localparam longint LIMIT = 2000000;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] first;
    logic [31:0] second;
    logic        sat;
  } roots_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [3:0]  out_tuser;

  roots_t      roots_pending[$];
  int          fail_count = 0;
  longint      cycle_count = 0;
  logic [31:0] edge_vals[8] = '{32'h0, 32'h1, 32'hffffffff, 32'h7fffffff, 32'h80000000,
                                32'h00010000, 32'hffff0000, 32'h00020000};

  quadratic_root_solver uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // magnitude * 2^FB / den, truncated, clamped to the signed range
  function automatic logic [31:0] scaled_quot(input bit neg, input logic [127:0] m,
                                              input logic [127:0] den, inout bit sat);
    logic [127:0] q;
    logic [127:0] lim;
    q = (m << FB) / den;
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    if (q > lim) begin
      sat = 1'b1;
      q = lim;
    end
    return neg ? -q[31:0] : q[31:0];
  endfunction

  function automatic logic [127:0] floor_sqrt(input logic [127:0] n);
    logic [127:0] r;
    logic [127:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (128'h1 << b);
      if (c * c <= n) r = c;
    end
    return r;
  endfunction

  function automatic roots_t solve_roots(input logic [31:0] ra, input logic [31:0] rb,
                                         input logic [31:0] rc);
    roots_t res;
    longint sa, sb, sc, np, nm;
    logic [127:0] ma, mb, mc, den, b2, fac, disc, s;
    logic [31:0] rp, rm;
    bit dneg;
    bit sat;
    sa = longint'($signed(ra));
    sb = longint'($signed(rb));
    sc = longint'($signed(rc));
    ma = 128'(sa < 0 ? -sa : sa);
    mb = 128'(sb < 0 ? -sb : sb);
    mc = 128'(sc < 0 ? -sc : sc);
    sat = 1'b0;
    res = '0;
    if (sa == 0) begin
      if (sb == 0) begin
        res.kind = (sc == 0) ? KIND_ZERO : KIND_NONE;
      end else begin
        res.kind = KIND_LINEAR;
        res.first = scaled_quot(sc != 0 && ((sc < 0) == (sb < 0)), mc, mb, sat);
        res.second = res.first;
      end
    end else begin
      den = 2 * ma;
      b2 = mb * mb;
      fac = (ma * mc) << 2;
      dneg = 1'b0;
      if (sc != 0 && ((sa < 0) != (sc < 0))) disc = b2 + fac;
      else if (b2 >= fac) disc = b2 - fac;
      else begin
        disc = fac - b2;
        dneg = 1'b1;
      end
      s = floor_sqrt(disc);
      if (dneg) begin
        res.kind = KIND_COMPLEX;
        res.first = scaled_quot(sb != 0 && ((sb < 0) == (sa < 0)), mb, den, sat);
        res.second = scaled_quot(1'b0, s, den, sat);
      end else if (disc == 0) begin
        res.kind = KIND_DOUBLE;
        res.first = scaled_quot(sb != 0 && ((sb < 0) == (sa < 0)), mb, den, sat);
        res.second = res.first;
      end else begin
        np = -sb + longint'(s);
        nm = -sb - longint'(s);
        rp = scaled_quot(np != 0 && ((np < 0) != (sa < 0)), 128'(np < 0 ? -np : np),
                         den, sat);
        rm = scaled_quot(nm != 0 && ((nm < 0) != (sa < 0)), 128'(nm < 0 ? -nm : nm),
                         den, sat);
        res.kind = KIND_TWO;
        res.first = sa > 0 ? rp : rm;
        res.second = sa > 0 ? rm : rp;
      end
    end
    res.sat = sat;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
    fail_count++;
  endtask

  task automatic send_coefs(input logic [31:0] ca, input logic [31:0] cb,
                            input logic [31:0] cc);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {cc, cb, ca};
    roots_pending.push_back(solve_roots(ca, cb, cc));
    do @(posedge clk); while (!in_tready);
  endtask

  // result checker with random back-pressure
  initial begin
    roots_t want;
    int stall;
    @(posedge rst_n);
    forever begin
      stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      if (roots_pending.size() == 0) begin
        report_mismatch("unexpected transaction", out_tdata[31:0], 32'h0);
      end else begin
        want = roots_pending.pop_front();
        if (out_tuser[2:0] !== want.kind)
          report_mismatch("root_kind", 32'(out_tuser[2:0]), 32'(want.kind));
        if (out_tdata[31:0] !== want.first)
          report_mismatch("first_value", out_tdata[31:0], want.first);
        if (out_tdata[63:32] !== want.second)
          report_mismatch("second_value", out_tdata[63:32], want.second);
        if (out_tuser[3] !== want.sat)
          report_mismatch("saturated", 32'(out_tuser[3]), 32'(want.sat));
      end
    end
  end

  task automatic test_special_cases();
    send_coefs(0, 0, 0);
    send_coefs(0, 0, 32'h00030000);
    send_coefs(0, 32'h00020000, 32'hfffc0000);
    send_coefs(0, 32'h00000001, 32'h7fffffff);
    send_coefs(32'h00010000, 32'hfffd0000, 32'h00020000);
    send_coefs(32'h00010000, 32'h00020000, 32'h00010000);
    send_coefs(32'hffff0000, 32'h00020000, 32'hffff0000);
    send_coefs(32'h00010000, 32'h00020000, 32'h00050000);
    send_coefs(32'h00010000, 0, 32'h00040000);
    send_coefs(32'hffff0000, 32'h00020000, 32'hfffb0000);
    send_coefs(32'h00000001, 32'h7fffffff, 32'h80000000);
    send_coefs(32'h80000000, 32'h80000000, 32'h80000000);
    send_coefs(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_coefs(32'h7fffffff, 32'h80000000, 32'h00000001);
    send_coefs(32'h00000001, 32'h00000003, 32'h00000001);
  endtask

  task automatic test_edge_mix();
    for (int i = 0; i < 8; i++) begin
      send_coefs(edge_vals[$urandom_range(0, 7)], edge_vals[$urandom_range(0, 7)],
                 edge_vals[$urandom_range(0, 7)]);
    end
  endtask

  task automatic test_random_coefs();
    logic [31:0] ca, cb, cc, r;
    int pick;
    for (int i = 0; i < 1900; i++) begin
      ca = $urandom;
      cb = $urandom;
      cc = $urandom;
      pick = $urandom_range(0, 9);
      case (pick)
        0: ca = 0;
        1: begin
          ca = 0;
          cb = 0;
        end
        // build from chosen roots so double and small-root cases appear
        2: begin
          r = $signed($urandom) >>> 20;
          ca = $signed($urandom) >>> 24;
          cb = -2 * ca * r;
          cc = ca * r * r;
        end
        3, 4: begin
          ca = $signed(ca) >>> $urandom_range(8, 28);
          cb = $signed(cb) >>> $urandom_range(8, 28);
          cc = $signed(cc) >>> $urandom_range(8, 28);
        end
        default: ;
      endcase
      send_coefs(ca, cb, cc);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_special_cases();
    test_edge_mix();
    test_random_coefs();
    in_tvalid <= 1'b0;
    while (roots_pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && roots_pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
